FILE: hw/rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

	typedef logic [127:0] blk_t;

	localparam int NumRounds = 10;

	localparam logic [0:0] RegKeyHigh = 1'b0;
	localparam logic [0:0] RegKeyLow  = 1'b1;

	localparam logic [7:0] RedPoly = 8'h1b;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? RedPoly : 8'h00);
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aes_round.sv
`default_nettype none
// one round stage: registers the next state and the next round key
module aes_round #(
	parameter logic [3:0] Round = 4'd1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           vld,
	input  wire aes_pkg::blk_t  st,
	input  wire aes_pkg::blk_t  rk,
	output logic                vld_s1,
	output aes_pkg::blk_t       st_s1,
	output aes_pkg::blk_t       rk_s1
);
	import aes_pkg::*;

	logic [7:0] sb [16];
	logic [7:0] sh [16];
	logic [7:0] mc [16];
	blk_t nk;
	blk_t ns;
	logic [31:0] w [4];
	logic [31:0] t;

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			sb[j] = sbox(st[127 - 8*j -: 8]);
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sh[c*4 + r] = sb[((c + r) % 4)*4 + r];
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				mc[c*4 + r] = sh[c*4 + r] ^ sh[c*4] ^ sh[c*4 + 1] ^ sh[c*4 + 2]
					^ sh[c*4 + 3] ^ xtime(sh[c*4 + r] ^ sh[c*4 + (r + 1) % 4]);
			end
		end
		// key schedule for this round
		t = {sbox(rk[23:16]) ^ rcon(Round), sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
		w[0] = rk[127:96] ^ t;
		w[1] = rk[95:64] ^ w[0];
		w[2] = rk[63:32] ^ w[1];
		w[3] = rk[31:0] ^ w[2];
		nk = {w[0], w[1], w[2], w[3]};
		for (int j = 0; j < 16; j++) begin
			ns[127 - 8*j -: 8] = ((Round == 4'(NumRounds)) ? sh[j] : mc[j]) ^ nk[127 - 8*j -: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		st_s1 <= ns;
		rk_s1 <= nk;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/aes128_block_encrypt.sv
`default_nettype none
// AES-128 encryption pipeline: one block may start every cycle, and its
// ciphertext appears with done high after one register stage for the
// initial key addition and then one per round, each with its own key
// expansion step. The key in use is the one held when start is taken.
// busy is always low; the receiver must take each result in the cycle
// done is high.
module aes128_block_encrypt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] plain_high,
	input  wire logic [63:0] plain_low,
	output logic             done,
	output logic [63:0]      cipher_high,
	output logic [63:0]      cipher_low,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import aes_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic        vld_s0;
	blk_t        st_s0;
	blk_t        rk_s0;
	logic        vld [NumRounds + 1];
	blk_t        st [NumRounds + 1];
	blk_t        rk [NumRounds + 1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			vld_s0     <= 1'b0;
		end else begin
			vld_s0 <= start;
			if (cfg_we) begin
				case (cfg_index)
					RegKeyHigh: key_high_q <= cfg_data;
					RegKeyLow:  key_low_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		st_s0 <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
		rk_s0 <= {key_high_q, key_low_q};
	end

	assign vld[0] = vld_s0;
	assign st[0]  = st_s0;
	assign rk[0]  = rk_s0;

	for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
		aes_round #(.Round(4'(g))) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vld[g-1]),
			.st     (st[g-1]),
			.rk     (rk[g-1]),
			.vld_s1 (vld[g]),
			.st_s1  (st[g]),
			.rk_s1  (rk[g])
		);
	end

	assign done        = vld[NumRounds];
	assign cipher_high = st[NumRounds][127:64];
	assign cipher_low  = st[NumRounds][63:0];

endmodule
`default_nettype wire
